/* design/rhp_pkg.sv */
package rhp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUO_BITS    = 8;
  localparam int unsigned HREM_W      = 20;
  localparam int unsigned HDIV_W      = 12;
  localparam int unsigned SREM_W      = 17;
  localparam int unsigned SDIV_W      = 9;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // Numerators and divisors of both divisions plus the value channel.
  typedef struct packed {
    logic [HREM_W-1:0] num_h;
    logic [HDIV_W-1:0] div_h;
    logic [SREM_W-1:0] num_s;
    logic [SDIV_W-1:0] div_s;
    logic [7:0]        val;
  } job_t;

  typedef struct packed {
    logic [HREM_W-1:0]   rem_h;
    logic [HDIV_W-1:0]   div_h;
    logic [QUO_BITS-1:0] quo_h;
    logic [SREM_W-1:0]   rem_s;
    logic [SDIV_W-1:0]   div_s;
    logic [QUO_BITS-1:0] quo_s;
    logic [7:0]          val;
  } stage_t;

  typedef struct packed {
    logic [HREM_W-1:0] rem;
    logic              hit;
  } step_t;

  // One restoring division step: try to take the divisor shifted by sh.
  function automatic step_t div_step(logic [HREM_W-1:0] rem, logic [HDIV_W-1:0] dv,
                                     logic [2:0] sh);
    logic [HREM_W-1:0] sd;
    step_t             r;
    sd = {{(HREM_W-HDIV_W){1'b0}}, dv} << sh;
    if (rem >= sd) begin
      r.rem = rem - sd;
      r.hit = 1'b1;
    end else begin
      r.rem = rem;
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

/* design/rgb_to_hsv_pixel.sv */
// Path: a pixel transferred in is captured by the classify register at the
// transfer, then held in a queue entry, then passed through nine divider stages
// (load plus one quotient bit per stage for hue and saturation in parallel)
// to the outputs. Throughput: one pixel per cycle while the output is not stalled,
// set by the fully pipelined divider.
// Reset clears all valid bits and queue pointers; payload registers are not reset.
module rgb_to_hsv_pixel #(
  parameter int unsigned QUEUE_DEPTH = rhp_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] hue_o,
  output logic [7:0] saturation_o,
  output logic [7:0] brightness_o
);
  import rhp_pkg::*;

  logic job_valid, job_full, job_avail, job_pop;
  job_t job_in, job_out;

  rhp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .job_valid_o (job_valid),
    .job_full_i  (job_full),
    .job_o       (job_in)
  );

  rhp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_valid && !job_full),
    .push_data_i (job_in),
    .full_o      (job_full),
    .pop_i       (job_pop),
    .avail_o     (job_avail),
    .pop_data_o  (job_out)
  );

  rhp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_avail_i  (job_avail),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

endmodule

/* design/rhp_front.sv */
module rhp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  output logic          job_valid_o,
  input  logic          job_full_i,
  output rhp_pkg::job_t job_o
);
  import rhp_pkg::*;

  logic    valid_q;
  job_t    job_q, job_d;
  sector_e sector;
  logic [7:0]  mx, mn, d;
  logic [10:0] d6, hn;
  logic        load;

  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      mx     = red_i;
      sector = SEC_RED;
    end else if (green_i >= blue_i) begin
      mx     = green_i;
      sector = SEC_GREEN;
    end else begin
      mx     = blue_i;
      sector = SEC_BLUE;
    end
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d  = mx - mn;
    d6 = {1'b0, d, 2'b0} + {2'b0, d, 1'b0};

    unique case (sector)
      SEC_RED: begin
        if (green_i >= blue_i) hn = {3'b0, green_i - blue_i};
        else hn = d6 - {3'b0, blue_i - green_i};
      end
      SEC_GREEN: hn = ({2'b0, d, 1'b0} + {3'b0, blue_i}) - {3'b0, red_i};
      SEC_BLUE:  hn = ({1'b0, d, 2'b0} + {3'b0, red_i}) - {3'b0, green_i};
      default:   hn = '0;
    endcase

    job_d.num_h = ({hn, 9'b0} - {8'b0, hn, 1'b0}) + {9'b0, d6};
    job_d.num_s = ({d, 9'b0} - {8'b0, d, 1'b0}) + {9'b0, mx};
    // A zero divisor only occurs with a zero numerator, so one gives a zero quotient.
    job_d.div_h = (d == 8'd0) ? 12'd1 : ({1'b0, d, 3'b0} + {2'b0, d, 2'b0});
    job_d.div_s = (mx == 8'd0) ? 9'd1 : {mx, 1'b0};
    job_d.val   = mx;
  end

  assign in_stall_o  = valid_q && job_full_i;
  assign load        = !valid_q || !job_full_i;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      job_q <= job_d;
    end
  end

endmodule

/* design/rhp_queue.sv */
module rhp_queue #(
  parameter int unsigned DEPTH = rhp_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rhp_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          avail_o,
  output rhp_pkg::job_t pop_data_o
);
  import rhp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          entry_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign avail_o    = (cnt_q != '0);
  assign pop_data_o = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* design/rhp_back.sv */
module rhp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_avail_i,
  input  rhp_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    hue_o,
  output logic [7:0]    saturation_o,
  output logic [7:0]    brightness_o
);
  import rhp_pkg::*;

  localparam int unsigned NST = QUO_BITS + 1;

  stage_t         st_q [NST];
  logic [NST-1:0] v_q, adv, ld;

  // A stage moves on when the next one is empty or moving on too.
  always_comb begin
    adv[NST-1] = v_q[NST-1] && !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = v_q[k] && (!v_q[k+1] || adv[k+1]);
    end
    for (int k = 0; k < NST; k++) begin
      ld[k] = !v_q[k] || adv[k];
    end
  end

  assign job_pop_o = job_avail_i && ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= job_avail_i;
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      st_q[0].rem_h <= job_i.num_h;
      st_q[0].div_h <= job_i.div_h;
      st_q[0].quo_h <= '0;
      st_q[0].rem_s <= job_i.num_s;
      st_q[0].div_s <= job_i.div_s;
      st_q[0].quo_s <= '0;
      st_q[0].val   <= job_i.val;
    end
  end

  // Stage k resolves quotient bit QUO_BITS-k, most significant first.
  for (genvar k = 1; k < NST; k++) begin : g_stage
    step_t sh, ss;
    assign sh = div_step(st_q[k-1].rem_h, st_q[k-1].div_h, 3'(QUO_BITS - k));
    assign ss = div_step({{(HREM_W-SREM_W){1'b0}}, st_q[k-1].rem_s},
                         {{(HDIV_W-SDIV_W){1'b0}}, st_q[k-1].div_s}, 3'(QUO_BITS - k));

    always_ff @(posedge clk_i) begin
      if (ld[k] && v_q[k-1]) begin
        st_q[k].rem_h <= sh.rem;
        st_q[k].div_h <= st_q[k-1].div_h;
        st_q[k].quo_h <= {st_q[k-1].quo_h[QUO_BITS-2:0], sh.hit};
        st_q[k].rem_s <= ss.rem[SREM_W-1:0];
        st_q[k].div_s <= st_q[k-1].div_s;
        st_q[k].quo_s <= {st_q[k-1].quo_s[QUO_BITS-2:0], ss.hit};
        st_q[k].val   <= st_q[k-1].val;
      end
    end
  end

  assign out_valid_o  = v_q[NST-1];
  assign hue_o        = st_q[NST-1].quo_h;
  assign saturation_o = st_q[NST-1].quo_s;
  assign brightness_o = st_q[NST-1].val;

endmodule

/* design/rhp_checker.sv */
module rhp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] hue_o,
  input logic [7:0] saturation_o,
  input logic [7:0] brightness_o
);

  // A result that is held off must stay in place until it is transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hue_o)
      && $stable(saturation_o) && $stable(brightness_o))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(red_i)
      && $stable(green_i) && $stable(blue_i))
    else $error("stalled input changed");

  // Black pixels carry neither hue nor saturation.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brightness_o == 8'd0 |-> hue_o == 8'd0 && saturation_o == 8'd0)
    else $error("black pixel with hue or saturation");

  // Zero saturation only happens for grey, which has zero hue.
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturation_o == 8'd0 |-> hue_o == 8'd0)
    else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_pixel rhp_checker u_rhp_checker (.*);

/* test/tb_rgb_to_hsv_pixel.sv */
`timescale 1ns / 100ps

module tb_rgb_to_hsv_pixel;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bit         known;
    hsv_t       hsv;
  } pixel_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] red_i = '0;
  logic [7:0] green_i = '0;
  logic [7:0] blue_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] hue_o;
  logic [7:0] saturation_o;
  logic [7:0] brightness_o;

  hsv_t expected_hsv[$];
  int   fail_count = 0;
  bit   quiet_phase = 1'b0;

  rgb_to_hsv_pixel dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic hsv_t rgb_to_hsv(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned ur, ug, ub, mx, mn, d, hn, h, s;
    int          sector;
    hsv_t        o;
    ur = {24'd0, r};
    ug = {24'd0, g};
    ub = {24'd0, b};
    if (ur >= ug && ur >= ub) begin
      mx = ur; sector = 0;
    end else if (ug >= ub) begin
      mx = ug; sector = 1;
    end else begin
      mx = ub; sector = 2;
    end
    mn = ur;
    if (ug < mn) mn = ug;
    if (ub < mn) mn = ub;
    d = mx - mn;
    h = 0;
    s = 0;
    if (mx != 0) s = (510 * d + mx) / (2 * mx);
    if (d != 0) begin
      if (sector == 0) hn = (ug >= ub) ? ug - ub : 6 * d - (ub - ug);
      else if (sector == 1) hn = 2 * d + ub - ur;
      else hn = 4 * d + ur - ug;
      h = (510 * hn + 6 * d) / (12 * d);
    end
    if (h > 255) h = 255;
    if (s > 255) s = 255;
    o.hue = h[7:0];
    o.sat = s[7:0];
    o.val = mx[7:0];
    return o;
  endfunction

  // Sends one pixel and holds it until the transfer completes.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit known,
                            hsv_t hsv);
    while (!quiet_phase && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    expected_hsv.push_back(known ? hsv : rgb_to_hsv(r, g, b));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hsv.size() == 0) begin
        $error("unexpected transfer hue=%0d sat=%0d val=%0d",
               hue_o, saturation_o, brightness_o);
        fail_count++;
      end else begin
        hsv_t e;
        e = expected_hsv.pop_front();
        if (hue_o !== e.hue) begin
          $error("hue: expected %0d, actual %0d", e.hue, hue_o); fail_count++;
        end
        if (saturation_o !== e.sat) begin
          $error("saturation: expected %0d, actual %0d", e.sat, saturation_o); fail_count++;
        end
        if (brightness_o !== e.val) begin
          $error("brightness: expected %0d, actual %0d", e.val, brightness_o); fail_count++;
        end
      end
    end
    out_stall_i <= rst_ni && !quiet_phase && ($urandom_range(99) < 7);
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    pixel_row_t rows[$];
    logic [7:0] r, g, b;
    int         wait_cycles;
    // Black, white, grey, pure primaries and secondaries, ties and the hue wrap near the full circle.
    rows = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
      '{8'd128, 8'd128, 8'd128, 1'b1, '{8'd0,   8'd0,   8'd128}},
      '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd255}},
      '{8'd0,   8'd255, 8'd0,   1'b1, '{8'd85,  8'd255, 8'd255}},
      '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd170, 8'd255, 8'd255}},
      '{8'd255, 8'd255, 8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd255, 8'd0,   8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd0,   8'd255, 8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd255, 8'd0,   8'd1,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd1,   8'd0,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd1,   8'd1,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd0,   8'd0,   8'd1,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd254, 8'd253, 8'd255, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd200, 8'd100, 8'd150, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd170, 8'd85,  8'd85,  1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd85,  8'd170, 8'd170, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd255, 8'd1,   8'd0,   1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd100, 8'd200, 8'd200, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{8'd1,   8'd2,   8'd3,   1'b0, '{8'd0, 8'd0, 8'd0}}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].known, rows[i].hsv);
    for (int n = 0; n < 1150; n++) begin
      quiet_phase = (n >= 500 && n < 700);
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      case ($urandom_range(5))
        0: g = r;
        1: b = g;
        2: begin g = r; b = r; end
        3: begin
          r = 8'($urandom_range(3));
          g = 8'($urandom_range(3));
          b = 8'($urandom_range(3));
        end
        default: ;
      endcase
      send_pixel(r, g, b, 1'b0, '0);
    end
    quiet_phase = 1'b0;
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (expected_hsv.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && expected_hsv.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
